FILE: design/pbl_pkg.sv
// pbl_pkg: shared widths, types and arithmetic for the premultiplied pixel blend core
// used by the channel interfaces and by premultiplied_pixel_blend_core
// depends on nothing
package pbl_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned ModeW = 3;
  localparam int unsigned NumW  = 18;

  // one scale squared, the numerator of full coverage
  localparam logic [15:0] FullNum = 16'd65025;
  // smallest numerator that gives 256 or more after the divide
  localparam logic [NumW-1:0] SatNum = 18'd65280;

  typedef logic [PixW-1:0] chan_t;
  typedef logic [NumW-1:0] num_t;

  typedef enum logic [ModeW-1:0] {
    MODE_NORMAL   = 3'd0,
    MODE_MULTIPLY = 3'd1,
    MODE_SCREEN   = 3'd2,
    MODE_DARKEN   = 3'd3,
    MODE_LIGHTEN  = 3'd4
  } blend_mode_e;

  typedef struct packed {
    chan_t dst_red;
    chan_t dst_green;
    chan_t dst_blue;
    chan_t dst_alpha;
    chan_t src_red;
    chan_t src_green;
    chan_t src_blue;
    chan_t src_alpha;
  } pix_pair_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } pix_t;

  // blended channel as a numerator over 255*255
  function automatic num_t blend_num(input chan_t d, input chan_t s, input chan_t da,
                                     input chan_t sa, input logic [ModeW-1:0] mode);
    chan_t       inv_da;
    chan_t       inv_sa;
    logic [15:0] p_ds;
    logic [15:0] p_ads;
    logic [15:0] p_asd;
    num_t        d255;
    num_t        s255;
    num_t        over_d;
    num_t        over_s;
    num_t        res;
    // 255 - x is the bitwise complement for 8-bit x, taken at 8 bits
    inv_da = ~da;
    inv_sa = ~sa;
    p_ds   = 16'(d * s);
    p_ads  = 16'(inv_da * s);
    p_asd  = 16'(inv_sa * d);
    d255   = NumW'({d, 8'b0}) - NumW'(d);
    s255   = NumW'({s, 8'b0}) - NumW'(s);
    over_d = NumW'(p_ads) + d255;
    over_s = NumW'(p_asd) + s255;
    case (mode)
      MODE_NORMAL:   res = over_d;
      MODE_MULTIPLY: res = NumW'(p_ads) + NumW'(p_asd) + NumW'(p_ds);
      MODE_SCREEN:   res = s255 + d255 - NumW'(p_ds);
      MODE_DARKEN:   res = (over_d < over_s) ? over_d : over_s;
      MODE_LIGHTEN:  res = (over_d > over_s) ? over_d : over_s;
      default:       res = d255;
    endcase
    return res;
  endfunction

  // floor(n / 255) saturated at 255; exact add-and-shift form below 65280
  function automatic chan_t to_byte(input num_t n);
    logic [16:0] t;
    chan_t       q;
    t = 17'(n[15:0]) + 17'(n[15:8]) + 17'd1;
    if (n >= SatNum) begin
      q = '1;
    end else begin
      q = t[15:8];
    end
    return q;
  endfunction

  // combined alpha numerator: 255*255 - (255-da)(255-sa)
  function automatic num_t alpha_num(input chan_t da, input chan_t sa);
    chan_t       inv_da;
    chan_t       inv_sa;
    logic [15:0] p;
    inv_da = ~da;
    inv_sa = ~sa;
    p = 16'(inv_da * inv_sa);
    return NumW'(FullNum - p);
  endfunction

endpackage

FILE: design/pbl_in_if.sv
// pbl_in_if: input channel carrying one destination and source pixel pair per word
// depends on pbl_pkg for the channel width
interface pbl_in_if;
  logic            valid;
  logic            ready;
  pbl_pkg::chan_t  dst_red;
  pbl_pkg::chan_t  dst_green;
  pbl_pkg::chan_t  dst_blue;
  pbl_pkg::chan_t  dst_alpha;
  pbl_pkg::chan_t  src_red;
  pbl_pkg::chan_t  src_green;
  pbl_pkg::chan_t  src_blue;
  pbl_pkg::chan_t  src_alpha;

  modport source (
    output valid, dst_red, dst_green, dst_blue, dst_alpha,
           src_red, src_green, src_blue, src_alpha,
    input  ready
  );

  modport sink (
    input  valid, dst_red, dst_green, dst_blue, dst_alpha,
           src_red, src_green, src_blue, src_alpha,
    output ready
  );
endinterface

FILE: design/pbl_out_if.sv
// pbl_out_if: output channel carrying one blended pixel per word
// depends on pbl_pkg for the channel width
interface pbl_out_if;
  logic            valid;
  logic            ready;
  pbl_pkg::chan_t  out_red;
  pbl_pkg::chan_t  out_green;
  pbl_pkg::chan_t  out_blue;
  pbl_pkg::chan_t  out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

FILE: design/premultiplied_pixel_blend_core.sv
// premultiplied_pixel_blend_core: blends a premultiplied rgba pixel pair by blend mode
// pipeline: an accepted word goes from the input reg to the result reg once that is free
// throughput: one word per cycle unless stalled, set by the single blend pass between both regs
// reset: valid flags cleared, blend mode set to normal
// depends on pbl_pkg, pbl_in_if, pbl_out_if
module premultiplied_pixel_blend_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      blend_mode_we_i,
  input  logic [pbl_pkg::ModeW-1:0] blend_mode_i,
  pbl_in_if.sink                    in_i,
  pbl_out_if.source                 out_o
);

  logic [pbl_pkg::ModeW-1:0] mode_q;
  logic                      in_vld_q;
  pbl_pkg::pix_pair_t        in_pix_q;
  logic                      out_vld_q;
  pbl_pkg::pix_t             out_pix_q;
  pbl_pkg::pix_t             out_pix_d;
  logic                      out_free;
  logic                      adv;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pbl_pkg::MODE_NORMAL;
    end else if (blend_mode_we_i) begin
      mode_q <= blend_mode_i;
    end
  end

  // handshake: result reg frees up when empty or taken, input reg when it moves on
  assign out_free   = !out_vld_q || out_o.ready;
  assign adv        = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_pix_q <= '{dst_red:   in_i.dst_red,
                    dst_green: in_i.dst_green,
                    dst_blue:  in_i.dst_blue,
                    dst_alpha: in_i.dst_alpha,
                    src_red:   in_i.src_red,
                    src_green: in_i.src_green,
                    src_blue:  in_i.src_blue,
                    src_alpha: in_i.src_alpha};
    end
  end

  // blend pass
  always_comb begin
    out_pix_d.red   = pbl_pkg::to_byte(pbl_pkg::blend_num(in_pix_q.dst_red,
                        in_pix_q.src_red, in_pix_q.dst_alpha, in_pix_q.src_alpha, mode_q));
    out_pix_d.green = pbl_pkg::to_byte(pbl_pkg::blend_num(in_pix_q.dst_green,
                        in_pix_q.src_green, in_pix_q.dst_alpha, in_pix_q.src_alpha, mode_q));
    out_pix_d.blue  = pbl_pkg::to_byte(pbl_pkg::blend_num(in_pix_q.dst_blue,
                        in_pix_q.src_blue, in_pix_q.dst_alpha, in_pix_q.src_alpha, mode_q));
    out_pix_d.alpha = pbl_pkg::to_byte(pbl_pkg::alpha_num(in_pix_q.dst_alpha,
                        in_pix_q.src_alpha));
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q <= out_pix_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_red   = out_pix_q.red;
  assign out_o.out_green = out_pix_q.green;
  assign out_o.out_blue  = out_pix_q.blue;
  assign out_o.out_alpha = out_pix_q.alpha;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for premultiplied_pixel_blend_core, all blend modes and spare codes
// depends on pbl_pkg, pbl_in_if, pbl_out_if and the core itself
module tb;

  localparam int unsigned ModeW = pbl_pkg::ModeW;

  typedef pbl_pkg::chan_t     chan_t;
  typedef pbl_pkg::pix_t      pix_t;
  typedef pbl_pkg::pix_pair_t pix_pair_t;

  // codes past lighten, which pass the destination colour through
  localparam logic [ModeW-1:0] ModeSpare5 = 3'd5;
  localparam logic [ModeW-1:0] ModeSpare6 = 3'd6;
  localparam logic [ModeW-1:0] ModeSpare7 = 3'd7;
  localparam int unsigned Scale     = 255;
  localparam int unsigned StallMax  = 6;
  localparam int unsigned IdleLimit = 400;
  localparam int unsigned SettleCyc = 6;
  localparam int unsigned PhaseLen  = 100;
  localparam int unsigned NumPhases = 14;

  logic              clk_i;
  logic              rst_ni;
  logic              blend_mode_we_i;
  logic [ModeW-1:0]  blend_mode_i;

  pbl_in_if  in_if ();
  pbl_out_if out_if ();

  premultiplied_pixel_blend_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .blend_mode_we_i (blend_mode_we_i),
    .blend_mode_i    (blend_mode_i),
    .in_i            (in_if),
    .out_o           (out_if)
  );

  pix_t             expected_pixels[$];
  logic [ModeW-1:0] active_mode;
  bit               no_gaps;
  int unsigned      mismatches;
  int unsigned      idle_cycles;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // blended channel as a numerator over 255*255
  function automatic int unsigned channel_num(input int unsigned d, input int unsigned s,
                                              input int unsigned da, input int unsigned sa,
                                              input logic [ModeW-1:0] mode);
    int unsigned over_d;
    int unsigned over_s;
    over_d = (Scale - da) * s + Scale * d;
    over_s = (Scale - sa) * d + Scale * s;
    case (mode)
      pbl_pkg::MODE_NORMAL:   return over_d;
      pbl_pkg::MODE_MULTIPLY: return (Scale - da) * s + (Scale - sa) * d + d * s;
      pbl_pkg::MODE_SCREEN:   return Scale * (s + d) - d * s;
      pbl_pkg::MODE_DARKEN:   return (over_d < over_s) ? over_d : over_s;
      pbl_pkg::MODE_LIGHTEN:  return (over_d > over_s) ? over_d : over_s;
      default:                return Scale * d;
    endcase
  endfunction

  // truncating divide back to the byte scale, saturating at full
  function automatic chan_t num_to_level(input int unsigned n);
    int unsigned q;
    q = n / Scale;
    return (q > Scale) ? chan_t'(Scale) : chan_t'(q);
  endfunction

  function automatic pix_t blend_predict(input pix_pair_t p, input logic [ModeW-1:0] mode);
    pix_t r;
    r.red   = num_to_level(channel_num(p.dst_red, p.src_red, p.dst_alpha, p.src_alpha, mode));
    r.green = num_to_level(channel_num(p.dst_green, p.src_green, p.dst_alpha, p.src_alpha,
                                       mode));
    r.blue  = num_to_level(channel_num(p.dst_blue, p.src_blue, p.dst_alpha, p.src_alpha,
                                       mode));
    r.alpha = num_to_level(Scale * Scale - (Scale - p.dst_alpha) * (Scale - p.src_alpha));
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // send one pixel pair, valid stays high after acceptance until the next call
  task automatic send_pair(input pix_pair_t p);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, StallMax);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.dst_red   <= p.dst_red;
    in_if.dst_green <= p.dst_green;
    in_if.dst_blue  <= p.dst_blue;
    in_if.dst_alpha <= p.dst_alpha;
    in_if.src_red   <= p.src_red;
    in_if.src_green <= p.src_green;
    in_if.src_blue  <= p.src_blue;
    in_if.src_alpha <= p.src_alpha;
    do @(posedge clk_i); while (!in_if.ready);
    expected_pixels.push_back(blend_predict(p, active_mode));
  endtask

  // drop valid and wait for every outstanding word
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_blend_mode(input logic [ModeW-1:0] mode);
    drain_results();
    repeat (SettleCyc) @(negedge clk_i);
    blend_mode_we_i <= 1'b1;
    blend_mode_i    <= mode;
    @(negedge clk_i);
    blend_mode_we_i <= 1'b0;
    active_mode = mode;
  endtask

  // channel level, weighted toward the ends of the range
  function automatic chan_t pick_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly well-formed premultiplied pairs, the rest with colour free to exceed alpha
  function automatic pix_pair_t pick_pair();
    pix_pair_t p;
    p.dst_alpha = pick_level();
    p.src_alpha = pick_level();
    if ($urandom_range(0, 9) < 6) begin
      p.dst_red   = chan_t'($urandom_range(0, p.dst_alpha));
      p.dst_green = chan_t'($urandom_range(0, p.dst_alpha));
      p.dst_blue  = chan_t'($urandom_range(0, p.dst_alpha));
      p.src_red   = chan_t'($urandom_range(0, p.src_alpha));
      p.src_green = chan_t'($urandom_range(0, p.src_alpha));
      p.src_blue  = chan_t'($urandom_range(0, p.src_alpha));
    end else begin
      p.dst_red   = pick_level();
      p.dst_green = pick_level();
      p.dst_blue  = pick_level();
      p.src_red   = pick_level();
      p.src_green = pick_level();
      p.src_blue  = pick_level();
    end
    return p;
  endfunction

  // corner pixels: saturating colour above alpha, all clear, mixed opaque
  function automatic pix_pair_t corner_pair(input int unsigned k);
    case (k % 3)
      0:       return '{8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0};
      1:       return '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      default: return '{8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd64, 8'd128};
    endcase
  endfunction

  // mode after reset must be normal, so no write first
  task automatic test_reset_mode();
    for (int unsigned k = 0; k < 3; k++) send_pair(corner_pair(k));
  endtask

  task automatic test_each_mode();
    logic [ModeW-1:0] mode;
    for (int unsigned m = 1; m < 8; m++) begin
      mode = ModeW'(m);
      write_blend_mode(mode);
      for (int unsigned k = 0; k < 3; k++) send_pair(corner_pair(k + m));
    end
  endtask

  // random phases, first the codes in order, then random codes
  task automatic test_random_phases();
    logic [ModeW-1:0] mode;
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      mode = (ph < 8) ? ModeW'(ph) : ModeW'($urandom_range(0, 7));
      write_blend_mode(mode);
      for (int unsigned n = 0; n < PhaseLen; n++) begin
        if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        // now and then the sender holds off until the pipe is empty
        if ($urandom_range(0, 49) == 0) drain_results();
        send_pair(pick_pair());
      end
      no_gaps = 1'b0;
    end
  endtask

  // result sink with random stalls
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, StallMax);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      @(negedge clk_i);
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    pix_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_pixels.pop_front();
        if (out_if.out_red !== want.red)
          report_mismatch($sformatf("red got %0d expected %0d", out_if.out_red, want.red));
        if (out_if.out_green !== want.green)
          report_mismatch($sformatf("green got %0d expected %0d", out_if.out_green,
                                    want.green));
        if (out_if.out_blue !== want.blue)
          report_mismatch($sformatf("blue got %0d expected %0d", out_if.out_blue, want.blue));
        if (out_if.out_alpha !== want.alpha)
          report_mismatch($sformatf("alpha got %0d expected %0d", out_if.out_alpha,
                                    want.alpha));
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL premultiplied_pixel_blend_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    rst_ni          = 1'b0;
    blend_mode_we_i = 1'b0;
    blend_mode_i    = '0;
    in_if.valid     = 1'b0;
    in_if.dst_red   = '0;
    in_if.dst_green = '0;
    in_if.dst_blue  = '0;
    in_if.dst_alpha = '0;
    in_if.src_red   = '0;
    in_if.src_green = '0;
    in_if.src_blue  = '0;
    in_if.src_alpha = '0;
    active_mode     = pbl_pkg::MODE_NORMAL;
    no_gaps         = 1'b0;
    mismatches      = 0;
    idle_cycles     = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_mode();
    test_each_mode();
    test_random_phases();

    drain_results();
    repeat (SettleCyc) @(posedge clk_i);
    if (expected_pixels.size() != 0) report_mismatch("expected words left over");
    if (mismatches == 0) begin
      $display("PASS premultiplied_pixel_blend_core");
    end else begin
      $display("FAIL premultiplied_pixel_blend_core");
    end
    $finish;
  end

endmodule
